FILE: rtl/fcte_pkg.sv
// FAT entry engine package: action codes, status codes, store geometry.
// Used by fat_cluster_table_engine_unit and its checker.
package fcte_pkg;
  localparam int unsigned TableBytes = 131072;
  localparam int unsigned AddrW      = $clog2(TableBytes);

  localparam logic [2:0] ActLoad     = 3'd0;
  localparam logic [2:0] ActRead     = 3'd1;
  localparam logic [2:0] ActWrite    = 3'd2;
  localparam logic [2:0] ActAlloc    = 3'd3;
  localparam logic [2:0] ActValidate = 3'd4;
  localparam logic [2:0] ActFree     = 3'd5;

  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StBad  = 2'd1;
  localparam logic [1:0] StFull = 2'd2;
endpackage

FILE: rtl/fat_cluster_table_engine_unit.sv
// FAT entry engine top level: byte store, entry read/modify/write sequencer,
// allocate scan and chain walks. Depends on fcte_pkg.
//
// Usage: requests enter on in_valid_i/in_stall_o with action, cluster,
// entry value, byte address and byte data. Each request gives one result on
// out_valid_o/out_stall_i (status, cluster_out, end_of_chain). Registers
// fat_mode (index 0) and cluster_total (index 1) are written through
// cfg_valid_i/cfg_ready_o while the block is idle.
// One request is worked at a time. The store is one byte-wide synchronous
// RAM (one access a cycle, registered read data), so an entry costs two
// byte reads and up to two byte writes. An allocate reads one entry per
// cluster scanned and then writes the mark; a validate reads three links
// per step; a free is a validate followed by a read and a write per chain
// element.
// The result is held in an output register; a stall on the output holds
// it, and a new request is taken only once that result has left.
// Reset clears control state, the registers, hint and walk state; the
// store itself is undefined until loaded and gets no clearing pass.
`default_nettype none
module fat_cluster_table_engine_unit import fcte_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  action_i,
  input  wire logic [15:0] cluster_i,
  input  wire logic [15:0] entry_value_i,
  input  wire logic [16:0] byte_address_i,
  input  wire logic [7:0]  byte_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [15:0]      cluster_out_o,
  output logic             end_of_chain_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD0   = 4'd1;  // issue low byte read (scan: pick candidate)
  localparam logic [3:0] S_RD1   = 4'd2;  // issue high byte read (scan: low byte read)
  localparam logic [3:0] S_RD2   = 4'd3;  // scan: low byte returns, high read issued
  localparam logic [3:0] S_RD3   = 4'd4;  // high byte returns, use entry
  localparam logic [3:0] S_WR0   = 4'd5;  // write low byte
  localparam logic [3:0] S_WR1   = 4'd6;  // write high byte
  localparam logic [3:0] S_DONE  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  // what the entry read is for
  localparam logic [2:0] P_READ  = 3'd0;
  localparam logic [2:0] P_WRITE = 3'd1;
  localparam logic [2:0] P_SCAN  = 3'd2;
  localparam logic [2:0] P_SLOW  = 3'd3;
  localparam logic [2:0] P_FAST1 = 3'd4;
  localparam logic [2:0] P_FAST2 = 3'd5;
  localparam logic [2:0] P_FREE  = 3'd6;

  logic [7:0] mem_q [TableBytes];
  logic [7:0] rdata_q;

  logic        mode_q;
  logic [15:0] total_q;
  logic [15:0] hint_q, slow_q, fast_q;
  logic [16:0] steps_q;
  logic [3:0]  state_q, state_d;
  logic [2:0]  purp_q, purp_d;
  logic [2:0]  act_q;
  logic [15:0] cluster_i_q;
  logic [15:0] ent_cl_q, ent_cl_d;   // cluster whose entry is accessed
  logic [15:0] wval_q, wval_d;       // value to write
  logic [15:0] val_q;
  logic [15:0] scan_q, scan_d;       // scan offset for allocate
  logic [16:0] cnt_q, cnt_d;
  logic [7:0]  lo_q;
  logic [1:0]  st_q, st_d;
  logic [15:0] co_q, co_d;
  logic        eoc_q, eoc_d;
  logic        ovalid_q;

  // memory port
  logic        mwe;
  logic        mre;
  logic [16:0] maddr;
  logic [7:0]  mwdata;

  // entry address
  logic [16:0] off;
  logic [16:0] off1;
  logic        off_ok, off1_ok;
  assign off  = mode_q ? ({1'b0, ent_cl_q} + {2'b0, ent_cl_q[15:1]}) : {ent_cl_q, 1'b0};
  assign off1 = off + 17'd1;
  assign off_ok  = ({15'd0, off}  < 32'(TableBytes)) && (off1 != 17'd0 || off == 17'h1ffff);
  assign off1_ok = ({15'd0, off1} < 32'(TableBytes)) && (off1 != 17'd0);

  function automatic logic valid_cl(input logic [15:0] c, input logic [15:0] tot);
    return (c >= 16'd2) && ({1'b0, c} < ({1'b0, tot} + 17'd2));
  endfunction

  logic is_end_w;
  logic [15:0] entry_w;   // assembled entry in S_RD3
  logic [15:0] word_w;
  logic [7:0]  hi_byte;
  assign hi_byte = off1_ok ? rdata_q : 8'd0;
  assign word_w  = {hi_byte, lo_q};
  always_comb begin
    if (!mode_q) entry_w = word_w;
    else if (ent_cl_q[0]) entry_w = {4'd0, word_w[15:4]};
    else entry_w = {4'd0, word_w[11:0]};
  end
  assign is_end_w = mode_q ? (entry_w >= 16'h0ff8) : (entry_w >= 16'hfff8);

  logic [15:0] wv;
  assign wv = mode_q ? {4'd0, wval_q[11:0]} : wval_q;

  always_ff @(posedge clk_i) begin
    if (mwe) mem_q[maddr] <= mwdata;
    if (mre) rdata_q <= mem_q[maddr];
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;
  assign status_o = st_q;
  assign cluster_out_o = co_q;
  assign end_of_chain_o = eoc_q;

  // next allocate candidate from the scan offset
  logic [16:0] cand_sum;
  logic [15:0] cand;
  logic [15:0] start_w;
  assign start_w  = valid_cl(hint_q, total_q) ? hint_q : 16'd2;
  assign cand_sum = {1'b0, start_w - 16'd2} + {1'b0, scan_q};
  assign cand = (cand_sum >= {1'b0, total_q}) ? 16'(cand_sum - {1'b0, total_q}) + 16'd2
                                               : 16'(cand_sum) + 16'd2;

  logic [15:0] hint_d, slow_d, fast_d;
  logic [16:0] steps_d;
  logic [7:0]  lo_d;
  logic [15:0] val_d;

  always_comb begin
    state_d = state_q; purp_d = purp_q; ent_cl_d = ent_cl_q; wval_d = wval_q;
    scan_d = scan_q; cnt_d = cnt_q; st_d = st_q; co_d = co_q; eoc_d = eoc_q;
    hint_d = hint_q; slow_d = slow_q; fast_d = fast_q; steps_d = steps_q;
    lo_d = lo_q; val_d = val_q;
    mwe = 1'b0; mre = 1'b0; maddr = off; mwdata = 8'd0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          st_d = StOk; co_d = 16'd0; eoc_d = 1'b0;
          state_d = S_DONE;
          ent_cl_d = cluster_i; wval_d = entry_value_i;
          unique case (action_i) inside
            ActLoad: begin
              maddr = byte_address_i; mwdata = byte_data_i;
              mwe = ({15'd0, byte_address_i} < 32'(TableBytes));
            end
            ActRead: begin
              if (valid_cl(cluster_i, total_q)) begin
                purp_d = P_READ; state_d = S_RD0;
              end else st_d = StBad;
            end
            ActWrite: begin
              if (valid_cl(cluster_i, total_q)) begin
                purp_d = P_WRITE; state_d = S_RD0;
              end else st_d = StBad;
            end
            ActAlloc: begin
              if (total_q == 16'd0) st_d = StBad;
              else begin
                purp_d = P_SCAN; scan_d = 16'd0; state_d = S_RD0;
                ent_cl_d = 16'd0;  // set at S_RD0 from candidate
              end
            end
            ActValidate, ActFree: begin
              if (action_i == ActFree && cluster_i == 16'd0) st_d = StOk;
              else begin
                slow_d = cluster_i; fast_d = cluster_i; steps_d = 17'd0;
                if (!valid_cl(cluster_i, total_q)) st_d = StBad;
                else begin
                  purp_d = P_SLOW; state_d = S_RD0;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_RD0: begin
        if (purp_q == P_SCAN) begin
          ent_cl_d = cand;
          state_d = S_RD1;  // address used next cycle after ent_cl update
        end else begin
          mre = 1'b1; state_d = S_RD1;
        end
      end
      S_RD1: begin
        // scan: candidate now latched, low read here and high next
        mre = 1'b1;
        state_d = S_RD2;
        if (purp_q == P_SCAN) maddr = off;
        else begin
          maddr = off1;
          // low byte of a non-scan read arrives now
          lo_d = off_ok ? rdata_q : 8'd0;
        end
      end
      S_RD2: begin
        if (purp_q == P_SCAN) begin
          // scan: low byte back, issue high
          lo_d = off_ok ? rdata_q : 8'd0;
          mre = 1'b1; maddr = off1;
        end
        state_d = S_RD3;
      end
      S_RD3: begin
        val_d = entry_w;
        state_d = S_DONE;
        unique case (purp_q) inside
          P_READ: begin co_d = entry_w; eoc_d = is_end_w; end
          P_WRITE: state_d = S_WR0;
          P_SCAN: begin
            if (entry_w == 16'd0) begin
              co_d = ent_cl_q;
              hint_d = valid_cl(ent_cl_q + 16'd1, total_q) ? ent_cl_q + 16'd1 : 16'd2;
              wval_d = 16'hffff;
              state_d = S_WR0;
            end else if (scan_q + 16'd1 == total_q) st_d = StFull;
            else begin scan_d = scan_q + 16'd1; state_d = S_RD0; end
          end
          P_SLOW, P_FAST1, P_FAST2: begin
            if (is_end_w) begin
              st_d = StOk;
              if (act_q == ActFree) begin
                purp_d = P_FREE; ent_cl_d = cluster_i_q; cnt_d = 17'd0;
                state_d = (total_q == 16'd0) ? S_DONE : S_RD0;
                if (total_q == 16'd0) st_d = StBad;
              end
            end else if (!valid_cl(entry_w, total_q)) st_d = StBad;
            else if (purp_q == P_SLOW) begin
              slow_d = entry_w; purp_d = P_FAST1; ent_cl_d = fast_q; state_d = S_RD0;
            end else if (purp_q == P_FAST1) begin
              fast_d = entry_w; purp_d = P_FAST2; ent_cl_d = entry_w; state_d = S_RD0;
            end else begin
              fast_d = entry_w;
              if (slow_q == entry_w) st_d = StBad;
              else if (steps_q + 17'd1 > {1'b0, total_q}) begin
                steps_d = steps_q + 17'd1; st_d = StBad;
              end else begin
                steps_d = steps_q + 17'd1; purp_d = P_SLOW; ent_cl_d = slow_q;
                state_d = S_RD0;
              end
            end
          end
          P_FREE: begin
            wval_d = 16'd0; state_d = S_WR0;
          end
          default: ;
        endcase
      end
      S_WR0: begin
        // low byte; 12-bit odd merges low nibble from read data
        maddr = off; mwe = off_ok;
        if (!mode_q) mwdata = wv[7:0];
        else if (ent_cl_q[0]) mwdata = {wv[3:0], lo_q[3:0]};
        else mwdata = wv[7:0];
        state_d = S_WR1;
      end
      S_WR1: begin
        maddr = off1; mwe = off1_ok;
        if (!mode_q) mwdata = wv[15:8];
        else if (ent_cl_q[0]) mwdata = wv[11:4];
        else mwdata = {hi_byte[7:4], wv[11:8]};
        state_d = S_DONE;
        if (purp_q == P_FREE) begin
          if (mode_q ? (val_q >= 16'h0ff8) : (val_q >= 16'hfff8)) st_d = StOk;
          else if (cnt_q + 17'd1 >= {1'b0, total_q}) st_d = StBad;
          else if (!valid_cl(val_q, total_q)) st_d = StBad;
          else begin
            cnt_d = cnt_q + 17'd1; ent_cl_d = val_q; state_d = S_RD0;
          end
        end
      end
      S_DONE: state_d = S_OUT;
      S_OUT: if (!ovalid_q) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // scan: ent_cl updated in S_RD0, low read issued in S_RD1 with new ent_cl
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      cluster_i_q <= cluster_i;
      act_q <= action_i;
    end
    purp_q <= purp_d; ent_cl_q <= ent_cl_d; wval_q <= wval_d;
    scan_q <= scan_d; cnt_q <= cnt_d; lo_q <= lo_d; val_q <= val_d;
    co_q <= co_d; eoc_q <= eoc_d; st_q <= st_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; ovalid_q <= 1'b0; mode_q <= 1'b0; total_q <= 16'd0;
      hint_q <= 16'd0; slow_q <= 16'd0; fast_q <= 16'd0; steps_q <= 17'd0;
    end else begin
      state_q <= state_d;
      hint_q <= hint_d; slow_q <= slow_d; fast_q <= fast_d; steps_q <= steps_d;
      if (state_q == S_DONE) ovalid_q <= 1'b1;
      else if (ovalid_q && !out_stall_i) ovalid_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        if (!cfg_index_i) mode_q <= cfg_data_i[0];
        else total_q <= cfg_data_i;
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/fcte_checker.sv
// Port-level checker for fat_cluster_table_engine_unit, bound to the top.
// Depends on fcte_pkg.
`default_nettype none
module fcte_checker import fcte_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [1:0] status_o,
  input wire logic [15:0] cluster_out_o,
  input wire logic       end_of_chain_o
);
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3) else $error("bad status");
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StOk |-> cluster_out_o == 16'd0 && !end_of_chain_o)
    else $error("nonzero payload on failure");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o))
    else $error("stalled result changed");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o) else $error("request taken while busy");
endmodule

bind fat_cluster_table_engine_unit fcte_checker u_fcte_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .status_o(status_o),
  .cluster_out_o(cluster_out_o), .end_of_chain_o(end_of_chain_o)
);
`default_nettype wire

FILE: dv/fat_table_checker.sv
// Checker for fat_cluster_table_engine_unit: watches the request, result and
// register channels, predicts every result and compares it. Needs fcte_pkg.
`timescale 1ns / 100ps
module fat_table_checker import fcte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  action_i,
  input  logic [15:0] cluster_i,
  input  logic [15:0] entry_value_i,
  input  logic [16:0] byte_address_i,
  input  logic [7:0]  byte_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  status_i,
  input  logic [15:0] cluster_out_i,
  input  logic        end_of_chain_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] cluster;
    logic        eoc;
  } fat_result_t;

  logic [7:0]  fat_store [TableBytes];
  logic        twelve_bit;
  logic [15:0] data_clusters;
  logic [15:0] next_free_hint;
  logic [15:0] walk_slow, walk_fast;
  logic [16:0] walk_count;
  fat_result_t awaited_q [$];

  assign pending_o = awaited_q.size();

  function automatic int unsigned store_get(int unsigned a);
    return (a < TableBytes) ? int'(fat_store[a]) : 0;
  endfunction

  function automatic void store_put(int unsigned a, int unsigned v);
    if (a < TableBytes) fat_store[a] = v[7:0];
  endfunction

  function automatic bit in_range(int unsigned c);
    return c >= 2 && c < int'(data_clusters) + 2;
  endfunction

  function automatic bit is_eoc(int unsigned v);
    return v >= (twelve_bit ? 32'hff8 : 32'hfff8);
  endfunction

  function automatic int unsigned entry_addr(int unsigned c);
    return twelve_bit ? c + (c >> 1) : c * 2;
  endfunction

  function automatic int unsigned entry_get(int unsigned c);
    int unsigned o, w;
    o = entry_addr(c);
    w = store_get(o) | (store_get(o + 1) << 8);
    if (!twelve_bit) return w;
    return c[0] ? (w >> 4) : (w & 32'hfff);
  endfunction

  function automatic void entry_put(int unsigned c, int unsigned v);
    int unsigned o;
    o = entry_addr(c);
    if (!twelve_bit) begin
      store_put(o, v);
      store_put(o + 1, v >> 8);
    end else begin
      v &= 32'hfff;
      if (c[0]) begin
        store_put(o, (store_get(o) & 32'h0f) | ((v << 4) & 32'hf0));
        store_put(o + 1, v >> 4);
      end else begin
        store_put(o, v & 32'hff);
        store_put(o + 1, (store_get(o + 1) & 32'hf0) | ((v >> 8) & 32'h0f));
      end
    end
  endfunction

  // 0 moved, 1 end of chain, 2 corrupt link
  function automatic int follow(ref int unsigned p);
    int unsigned n;
    if (!in_range(p)) return 2;
    n = entry_get(p);
    if (is_eoc(n)) return 1;
    if (!in_range(n)) return 2;
    p = n;
    return 0;
  endfunction

  function automatic logic [1:0] check_chain(int unsigned first);
    int unsigned slow, fast, n;
    logic [1:0] st;
    int r;
    slow = first;
    fast = first;
    st = StBad;
    n = 0;
    if (in_range(first)) begin
      for (n = 0; n <= data_clusters; n++) begin
        r = follow(slow);
        if (r == 0) r = follow(fast);
        if (r == 0) r = follow(fast);
        if (r != 0) begin
          st = (r == 1) ? StOk : StBad;
          break;
        end
        if (slow == fast) break;
      end
    end
    walk_slow = slow[15:0];
    walk_fast = fast[15:0];
    walk_count = n[16:0];
    return st;
  endfunction

  function automatic logic [1:0] release_chain(int unsigned first);
    int unsigned c, n, k;
    logic [1:0] st;
    if (first == 0) return StOk;
    st = check_chain(first);
    if (st != StOk) return st;
    c = first;
    for (k = 0; k < data_clusters; k++) begin
      if (!in_range(c)) return StBad;
      n = entry_get(c);
      entry_put(c, 0);
      if (is_eoc(n)) return StOk;
      c = n;
    end
    return StBad;
  endfunction

  function automatic logic [1:0] grab_cluster(output logic [15:0] got);
    int unsigned start, i, c;
    got = '0;
    if (data_clusters == 0) return StBad;
    start = next_free_hint;
    if (!in_range(start)) start = 2;
    for (i = 0; i < data_clusters; i++) begin
      c = 2 + ((start - 2 + i) % data_clusters);
      if (entry_get(c) == 0) begin
        got = c[15:0];
        next_free_hint = c[15:0] + 16'd1;
        if (!in_range(next_free_hint)) next_free_hint = 16'd2;
        entry_put(c, twelve_bit ? 32'hfff : 32'hffff);
        return StOk;
      end
    end
    return StFull;
  endfunction

  function automatic fat_result_t predict(logic [2:0] act, int unsigned cl, int unsigned val,
                                          int unsigned addr, int unsigned dat);
    fat_result_t r;
    r = '0;
    case (act)
      ActLoad: store_put(addr, dat);
      ActRead: begin
        if (!in_range(cl)) r.status = StBad;
        else begin
          r.cluster = 16'(entry_get(cl));
          r.eoc = is_eoc(r.cluster);
        end
      end
      ActWrite: begin
        if (!in_range(cl)) r.status = StBad;
        else entry_put(cl, val);
      end
      ActAlloc: begin
        r.status = grab_cluster(r.cluster);
        if (r.status != StOk) r.cluster = '0;
      end
      ActValidate: r.status = check_chain(cl);
      ActFree: r.status = release_chain(cl);
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    fat_result_t e;
    if (!rst_ni) begin
      twelve_bit <= 1'b0;
      data_clusters <= '0;
      next_free_hint = '0;
      walk_slow = '0;
      walk_fast = '0;
      walk_count = '0;
      fail_count_o <= 0;
      awaited_q.delete();
    end else begin
      // result leaves before a new request can be worked, so pop first
      if (out_valid_i && !out_stall_i) begin
        if (awaited_q.size() == 0) begin
          $display("%0t: unexpected result st=%0d cl=%0h eoc=%0d", $time, status_i,
                   cluster_out_i, end_of_chain_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = awaited_q.pop_front();
          if (e.status !== status_i)
            $display("%0t: status exp %0d got %0d", $time, e.status, status_i);
          if (e.cluster !== cluster_out_i)
            $display("%0t: cluster_out exp %0h got %0h", $time, e.cluster, cluster_out_i);
          if (e.eoc !== end_of_chain_i)
            $display("%0t: end_of_chain exp %0d got %0d", $time, e.eoc, end_of_chain_i);
          if (e !== {status_i, cluster_out_i, end_of_chain_i})
            fail_count_o <= fail_count_o + 1;
        end
      end
      if (in_valid_i && !in_stall_i)
        awaited_q.push_back(predict(action_i, cluster_i, entry_value_i, byte_address_i,
                                    byte_data_i));
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == 1'b0) twelve_bit <= cfg_data_i[0];
        else data_clusters <= cfg_data_i;
      end
    end
  end
endmodule

FILE: dv/fat_cluster_table_engine_unit_tb.sv
// Top of the FAT entry engine testbench: clock, reset, requests, register
// phases and verdict. Depends on fcte_pkg, fat_table_checker and the block.
`timescale 1ns / 100ps
module fat_cluster_table_engine_unit_tb;
  import fcte_pkg::*;

  localparam int WatchLimit = 20000;
  localparam int PrefixTop  = 41;  // highest usable cluster when the table is huge

  logic        clk, rst_n;
  logic        in_valid, in_stall;
  logic [2:0]  action;
  logic [15:0] cluster, entry_value;
  logic [16:0] byte_address;
  logic [7:0]  byte_data;
  logic        out_valid, out_stall;
  logic [1:0]  status;
  logic [15:0] cluster_out;
  logic        end_of_chain;
  logic        cfg_valid, cfg_ready, cfg_index;
  logic [15:0] cfg_data;
  int          fail_count, pending;

  bit          quiet;      // no idling on either side
  bit          twelve;
  int          total, top_cl, sent, stall_left, idle_cycles;
  bit          huge;

  fat_cluster_table_engine_unit DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .action_i(action), .cluster_i(cluster), .entry_value_i(entry_value),
    .byte_address_i(byte_address), .byte_data_i(byte_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .cluster_out_o(cluster_out), .end_of_chain_o(end_of_chain),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  fat_table_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .action_i(action),
    .cluster_i(cluster), .entry_value_i(entry_value),
    .byte_address_i(byte_address), .byte_data_i(byte_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .status_i(status),
    .cluster_out_i(cluster_out), .end_of_chain_i(end_of_chain),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 2) == 0);
      stall_left <= pick_gap();
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles >= WatchLimit) begin
      $display("status: fail");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic send(logic [2:0] act, logic [15:0] cl, logic [15:0] val,
                      logic [16:0] addr, logic [7:0] dat);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    cluster <= cl;
    entry_value <= val;
    byte_address <= addr;
    byte_data <= dat;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic set_reg(logic idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int byte_of(int c);
    return twelve ? c + (c >> 1) : c * 2;
  endfunction

  function automatic logic [15:0] bad_cluster();
    if (total + 2 > 65535 || $urandom_range(0, 2) == 0) return 16'($urandom_range(0, 1));
    return 16'($urandom_range(total + 2, 65535));
  endfunction

  function automatic logic [15:0] any_cluster();
    if (top_cl < 2 || $urandom_range(0, 4) == 0) return bad_cluster();
    return 16'($urandom_range(2, top_cl));
  endfunction

  function automatic logic [15:0] eoc_value();
    return 16'hfff8 | 16'($urandom_range(0, 7));
  endfunction

  // link value; in twelve-bit mode the upper nibble is ignored, so fill it
  function automatic logic [15:0] link_to(int c);
    return twelve ? 16'(c) | 16'($urandom_range(0, 15) << 12) : 16'(c);
  endfunction

  // wait until every result is back and the block has gone quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic begin_phase(bit mode12, int n, bit big);
    int last;
    drain();
    twelve = mode12;
    total = n;
    huge = big;
    top_cl = big ? PrefixTop : n + 1;
    quiet = ($urandom_range(0, 3) == 0);
    set_reg(1'b0, 16'(mode12));
    set_reg(1'b1, 16'(n));
    // every byte a valid entry can touch is loaded before any read
    if (top_cl >= 2) begin
      last = byte_of(top_cl) + 1;
      for (int a = 0; a <= last; a++)
        send(ActLoad, 16'($urandom), 16'($urandom), 17'(a),
             (big || $urandom_range(0, 9) < 4) ? 8'h00 : 8'($urandom));
    end
  endtask

  task automatic build_chain();
    int len, links [6];
    bit dup;
    logic [15:0] tail;
    len = $urandom_range(1, (top_cl - 1 < 6) ? top_cl - 1 : 6);
    for (int i = 0; i < len; i++) begin
      do begin
        links[i] = $urandom_range(2, top_cl);
        dup = 1'b0;
        for (int j = 0; j < i; j++) if (links[j] == links[i]) dup = 1'b1;
      end while (dup);
    end
    for (int i = 0; i < len - 1; i++)
      send(ActWrite, 16'(links[i]), link_to(links[i + 1]), 17'($urandom), 8'($urandom));
    case ($urandom_range(0, 9))
      0, 1: tail = link_to(links[0]);   // closes a loop
      // link out of range; a packed huge table keeps only 12 bits, so use 0 or 1
      2:    tail = (huge && twelve) ? 16'($urandom_range(0, 1)) : bad_cluster();
      default: tail = eoc_value();
    endcase
    send(ActWrite, 16'(links[len - 1]), tail, 17'($urandom), 8'($urandom));
    if ($urandom_range(0, 1)) send(ActValidate, 16'(links[0]), 16'($urandom), 17'($urandom), 0);
    if ($urandom_range(0, 1)) send(ActFree, 16'(links[0]), 16'($urandom), 17'($urandom), 0);
  endtask

  task automatic random_items(int count);
    int stop, r;
    stop = sent + count;
    while (sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        // on a huge table, noise loads stay clear of the usable prefix
        send(ActLoad, 16'($urandom), 16'($urandom),
             huge ? 17'($urandom_range(byte_of(PrefixTop) + 2, TableBytes - 1))
                  : 17'($urandom_range(0, TableBytes - 1)), 8'($urandom));
      end else if (r < 24)
        send(ActRead, any_cluster(), 16'($urandom), 17'($urandom), 8'($urandom));
      else if (r < 38)
        send(ActWrite, any_cluster(),
             huge ? (top_cl >= 2 && $urandom_range(0, 1) ? link_to($urandom_range(2, top_cl))
                                                          : eoc_value())
                  : 16'($urandom), 17'($urandom), 8'($urandom));
      else if (r < 50 && !huge)
        send(ActAlloc, 16'($urandom), 16'($urandom), 17'($urandom), 8'($urandom));
      else if (r < 56)
        send(ActValidate, any_cluster(), 16'($urandom), 17'($urandom), 8'($urandom));
      else if (r < 62)
        send(ActFree, $urandom_range(0, 3) == 0 ? 16'd0 : any_cluster(), 16'($urandom),
             17'($urandom), 8'($urandom));
      else if (r < 65)
        send(3'($urandom_range(6, 7)), 16'($urandom), 16'($urandom), 17'($urandom),
             8'($urandom));
      else if (top_cl >= 2)
        build_chain();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    action = ActLoad;
    cluster = '0;
    entry_value = '0;
    byte_address = '0;
    byte_data = '0;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    quiet = 1'b0;
    sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: nothing is valid and allocate has no room
    begin_phase(1'b0, 0, 1'b0);
    send(ActAlloc, 0, 0, 0, 0);
    send(ActRead, 16'd2, 0, 0, 0);
    send(ActValidate, 16'd2, 0, 0, 0);
    send(ActFree, 16'd0, 0, 0, 0);
    send(ActLoad, 0, 0, 17'h1ffff, 8'hff);
    random_items(30);

    // packed entries: odd and even nibble merges, ends of the field ranges
    begin_phase(1'b1, 5, 1'b0);
    send(ActWrite, 16'd2, 16'hffff, 0, 0);
    send(ActWrite, 16'd3, 16'h0abc, 0, 0);
    send(ActRead, 16'd2, 0, 0, 0);
    send(ActRead, 16'd3, 0, 0, 0);
    send(ActRead, 16'd6, 0, 0, 0);
    send(ActRead, 16'd7, 0, 0, 0);
    send(ActRead, 16'hffff, 0, 0, 0);
    send(ActWrite, 16'd1, 16'h0000, 0, 0);
    send(ActAlloc, 0, 0, 0, 0);
    send(ActValidate, 16'd0, 0, 0, 0);
    send(ActFree, 16'd0, 0, 0, 0);
    send(ActFree, 16'd2, 0, 0, 0);
    send(3'd6, 16'hffff, 16'hffff, 17'h1ffff, 8'hff);
    send(3'd7, 0, 0, 0, 0);
    random_items(80);

    // single cluster: full table, then a freed one
    begin_phase(1'b0, 1, 1'b0);
    send(ActWrite, 16'd2, 16'h1234, 0, 0);
    send(ActAlloc, 0, 0, 0, 0);
    send(ActWrite, 16'd2, 16'h0000, 0, 0);
    send(ActAlloc, 0, 0, 0, 0);
    send(ActRead, 16'd2, 0, 0, 0);
    random_items(40);

    begin_phase(1'b0, 17, 1'b0);
    random_items(90);
    begin_phase(1'b1, 1, 1'b0);
    random_items(40);
    begin_phase(1'b1, 40, 1'b0);
    random_items(90);
    begin_phase(1'b1, 65517, 1'b1);
    random_items(80);
    begin_phase(1'b0, 65517, 1'b1);
    random_items(80);
    begin_phase(1'b0, 30, 1'b0);
    random_items(90);
    begin_phase(1'b1, 12, 1'b0);
    random_items(100);

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule

FILE: files.f
rtl/fcte_pkg.sv
rtl/fat_cluster_table_engine_unit.sv
rtl/fcte_checker.sv
dv/fat_table_checker.sv
dv/fat_cluster_table_engine_unit_tb.sv
